>>> design/grid_diffusion_evaporation_step_defines.svh
// Assertion macros for the diffusion stencil block.
`ifndef GRID_DIFFUSION_EVAPORATION_STEP_DEFINES_SVH
`define GRID_DIFFUSION_EVAPORATION_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GDES_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GDES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDES_ASSERT(label, ante, cons, msg)
`define GDES_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> design/gdes_pkg.sv
// Shared constants, register codes and types of the diffusion stencil block.
`timescale 1ns / 1ps
`default_nettype none

package gdes_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 512;
  localparam int LEVEL_BITS_DEF     = 16;

  localparam int COEF_W    = 16;
  localparam int GEOM_W    = 10;
  localparam int IDX_W     = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [GEOM_W-1:0] GEOM_MIN = 10'd3;
  localparam logic [GEOM_W-1:0] ROWS_MAX = 10'd512;

  localparam logic [COEF_W-1:0] DIFF_COEFF_RST      = 16'd655;
  localparam logic [COEF_W-1:0] KEEP_COEFF_RST      = 16'd30147;
  localparam logic [COEF_W-1:0] MAX_LEVEL_RST       = 16'd65280;
  localparam logic [COEF_W-1:0] FLOOR_THRESHOLD_RST = 16'd128;
  localparam logic [GEOM_W-1:0] ROW_LENGTH_RST      = 10'd300;
  localparam logic [GEOM_W-1:0] ROW_COUNT_RST       = 10'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_COEFF      = 3'd0,
    CFG_KEEP_COEFF      = 3'd1,
    CFG_MAX_LEVEL       = 3'd2,
    CFG_FLOOR_THRESHOLD = 3'd3,
    CFG_ROW_LENGTH      = 3'd4,
    CFG_ROW_COUNT       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctl_t;

endpackage

`default_nettype wire

>>> design/gdes_line_buf.sv
// Two line buffers holding the two rows above the current cell, registered read.
`timescale 1ns / 1ps
`default_nettype none

module gdes_line_buf #(
  parameter int DEPTH = gdes_pkg::MAX_ROW_LENGTH_DEF,
  parameter int WIDTH = gdes_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire gdes_pkg::lb_ctl_t        ctl,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_older,
  input  wire logic [WIDTH-1:0]         wr_recent,
  output logic      [WIDTH-1:0]         rd_older,
  output logic      [WIDTH-1:0]         rd_recent
);

  logic [WIDTH-1:0] older_mem  [DEPTH];
  logic [WIDTH-1:0] recent_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      older_mem[wr_addr]  <= wr_older;
      recent_mem[wr_addr] <= wr_recent;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_older  <= older_mem[rd_addr];
      rd_recent <= recent_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/grid_diffusion_evaporation_step.sv
// Top level of the five-point diffusion and evaporation stencil over a raster grid.
//
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_cell_level
// out_     output     out_valid / out_stall out_new_level, out_row_index, out_col_index,
//                                           out_frame_last
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One cell per cycle while in_stall is low. A result leaves, through the line-buffer read
// register, the multiply stage and the round/clamp output register, after the cell that
// closes its window (one row down, one column right of its center) is accepted.
// Border cells retire at the first stage and give no result.
// Reset clears control, counters and the window; the line buffers are not cleared.
// out_stall backs up stage by stage into in_stall; configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_diffusion_evaporation_step_defines.svh"

module grid_diffusion_evaporation_step #(
  parameter int MAX_ROW_LENGTH = gdes_pkg::MAX_ROW_LENGTH_DEF,
  parameter int LEVEL_BITS     = gdes_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [LEVEL_BITS-1:0]          in_cell_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [gdes_pkg::COEF_W-1:0]         out_new_level,
  output logic [gdes_pkg::IDX_W-1:0]          out_row_index,
  output logic [gdes_pkg::IDX_W-1:0]          out_col_index,
  output logic                                out_frame_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gdes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gdes_pkg::COEF_W-1:0]    cfg_data
);

  localparam int CW    = gdes_pkg::COEF_W;
  localparam int GW    = gdes_pkg::GEOM_W;
  localparam int IW    = gdes_pkg::IDX_W;
  localparam int COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W = ($clog2(MAX_ROW_LENGTH + 1) > GW) ? $clog2(MAX_ROW_LENGTH + 1) : GW;
  localparam int COLX  = (COL_W > IW) ? COL_W : IW;
  localparam int LAP_W = LEVEL_BITS + 3;
  localparam int PD_W  = LAP_W + CW + 1;
  localparam int PK_W  = LEVEL_BITS + CW;
  localparam int SUM_W = PD_W + 1;
  localparam int RND_W = SUM_W - CW;
  localparam int VW    = (RND_W > CW) ? RND_W : CW;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_LENGTH);

  // configuration registers
  logic [CW-1:0] diff_r, keep_r, max_r, floor_r;
  logic [GW-1:0] row_length_r, row_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r       <= gdes_pkg::DIFF_COEFF_RST;
      keep_r       <= gdes_pkg::KEEP_COEFF_RST;
      max_r        <= gdes_pkg::MAX_LEVEL_RST;
      floor_r      <= gdes_pkg::FLOOR_THRESHOLD_RST;
      row_length_r <= gdes_pkg::ROW_LENGTH_RST;
      row_count_r  <= gdes_pkg::ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (gdes_pkg::cfg_reg_t'(cfg_index))
        gdes_pkg::CFG_DIFF_COEFF:      diff_r       <= cfg_data;
        gdes_pkg::CFG_KEEP_COEFF:      keep_r       <= cfg_data;
        gdes_pkg::CFG_MAX_LEVEL:       max_r        <= cfg_data;
        gdes_pkg::CFG_FLOOR_THRESHOLD: floor_r      <= cfg_data;
        gdes_pkg::CFG_ROW_LENGTH:      row_length_r <= cfg_data[GW-1:0];
        gdes_pkg::CFG_ROW_COUNT:       row_count_r  <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [LEN_W-1:0] len_ext, len_eff;
  logic [GW-1:0]    rows_eff;

  always_comb begin
    len_ext = LEN_W'(row_length_r);
    if (len_ext < LEN_W'(gdes_pkg::GEOM_MIN)) begin
      len_eff = LEN_W'(gdes_pkg::GEOM_MIN);
    end else if (len_ext > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_ext;
    end
    if (row_count_r < gdes_pkg::GEOM_MIN) begin
      rows_eff = gdes_pkg::GEOM_MIN;
    end else if (row_count_r > gdes_pkg::ROWS_MAX) begin
      rows_eff = gdes_pkg::ROWS_MAX;
    end else begin
      rows_eff = row_count_r;
    end
  end

  // stage handshakes
  logic a_valid_r, a_emit_r, p_valid_r, out_valid_r;
  logic o_free, p_go, p_free, a_go, in_acc;

  assign o_free   = !out_valid_r || !out_stall;
  assign p_go     = p_valid_r && o_free;
  assign p_free   = !p_valid_r || p_go;
  assign a_go     = a_valid_r && (p_free || !a_emit_r);
  assign in_stall = a_valid_r && !a_go;
  assign in_acc   = in_valid && !in_stall;

  // raster position
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [IW-1:0]    row_cnt_r, row_cnt_nxt;
  logic [LEN_W-1:0] col_inc;
  logic [GW-1:0]    row_inc;
  logic [COLX-1:0]  col_m1;
  logic             emit_nxt, last_nxt;

  always_comb begin
    col_inc     = LEN_W'(col_cnt_r) + LEN_W'(1);
    row_inc     = GW'(row_cnt_r) + GW'(1);
    col_cnt_nxt = col_inc[COL_W-1:0];
    row_cnt_nxt = row_cnt_r;
    if (col_inc >= len_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= rows_eff) ? '0 : row_inc[IW-1:0];
    end
    col_m1   = COLX'(col_cnt_r) - COLX'(1);
    emit_nxt = (row_cnt_r >= IW'(2)) && (GW'(row_cnt_r) < rows_eff) &&
               (col_cnt_r >= COL_W'(2)) && (LEN_W'(col_cnt_r) < len_eff);
    last_nxt = (GW'(row_cnt_r) == rows_eff - GW'(1)) &&
               (LEN_W'(col_cnt_r) == len_eff - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // stage A: accepted cell and line-buffer read
  logic [LEVEL_BITS-1:0] a_x_r;
  logic [COL_W-1:0]      a_col_r;
  logic [IW-1:0]         a_row_idx_r, a_col_idx_r;
  logic                  a_last_r;
  logic [LEVEL_BITS-1:0] top_rd, mid_rd;
  gdes_pkg::lb_ctl_t     lb_ctl;

  assign lb_ctl.rd_en = in_acc;
  assign lb_ctl.wr_en = a_go;

  gdes_line_buf #(
    .DEPTH (MAX_ROW_LENGTH),
    .WIDTH (LEVEL_BITS)
  ) u_line_buf (
    .clk       (clk),
    .ctl       (lb_ctl),
    .rd_addr   (col_cnt_r),
    .wr_addr   (a_col_r),
    .wr_older  (mid_rd),
    .wr_recent (a_x_r),
    .rd_older  (top_rd),
    .rd_recent (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_emit_r  <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
      a_emit_r  <= emit_nxt;
    end else if (a_go) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x_r       <= in_cell_level;
      a_col_r     <= col_cnt_r;
      a_row_idx_r <= row_cnt_r - IW'(1);
      a_col_idx_r <= col_m1[IW-1:0];
      a_last_r    <= last_nxt;
    end
  end

  // window: up and down at c-1, middle row at c-2 and c-1
  logic [LEVEL_BITS-1:0] top_r, bot_r, midl_r, midc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      bot_r  <= '0;
      midl_r <= '0;
      midc_r <= '0;
    end else if (a_go) begin
      top_r  <= top_rd;
      bot_r  <= a_x_r;
      midl_r <= midc_r;
      midc_r <= mid_rd;
    end
  end

  // Laplacian and the two products
  logic signed [LAP_W-1:0] lap;
  logic signed [CW:0]      dco;
  logic signed [PD_W-1:0]  pd_nxt;
  logic        [PK_W-1:0]  pk_nxt;

  always_comb begin
    lap = $signed(LAP_W'(top_r)) + $signed(LAP_W'(bot_r)) + $signed(LAP_W'(midl_r)) +
          $signed(LAP_W'(mid_rd)) - $signed(LAP_W'({midc_r, 2'b00}));
    dco    = $signed({1'b0, diff_r});
    pd_nxt = PD_W'(dco) * PD_W'(lap);
    pk_nxt = PK_W'(keep_r) * PK_W'(midc_r);
  end

  // stage P: products
  logic signed [PD_W-1:0] p_pd_r;
  logic        [PK_W-1:0] p_pk_r;
  logic        [IW-1:0]   p_row_r, p_col_r;
  logic                   p_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (a_go && a_emit_r) begin
      p_valid_r <= 1'b1;
    end else if (p_go) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit_r) begin
      p_pd_r   <= pd_nxt;
      p_pk_r   <= pk_nxt;
      p_row_r  <= a_row_idx_r;
      p_col_r  <= a_col_idx_r;
      p_last_r <= a_last_r;
    end
  end

  // sum, round, saturate, floor
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] rnd;
  logic        [VW-1:0]    v_ext;
  logic        [CW-1:0]    lvl_sat, lvl_nxt;

  always_comb begin
    sum     = SUM_W'(p_pd_r) + $signed({{(SUM_W - PK_W - 1){1'b0}}, p_pk_r, 1'b0});
    rnd     = sum + SUM_W'(32768);
    v_ext   = VW'(rnd[SUM_W-1:CW]);
    lvl_sat = (v_ext > VW'(max_r)) ? max_r : v_ext[CW-1:0];
    if (sum[SUM_W-1] || (lvl_sat < floor_r)) begin
      lvl_nxt = '0;
    end else begin
      lvl_nxt = lvl_sat;
    end
  end

  // output register
  logic [CW-1:0] out_new_level_r;
  logic [IW-1:0] out_row_index_r, out_col_index_r;
  logic          out_frame_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go) begin
      out_new_level_r  <= lvl_nxt;
      out_row_index_r  <= p_row_r;
      out_col_index_r  <= p_col_r;
      out_frame_last_r <= p_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_level  = out_new_level_r;
  assign out_row_index  = out_row_index_r;
  assign out_col_index  = out_col_index_r;
  assign out_frame_last = out_frame_last_r;

  `GDES_ASSERT(a_empty_no_stall, !a_valid_r, !in_stall, "input stalled with stage A empty")
  `GDES_ASSERT_NEXT(a_fill_on_accept, in_acc, a_valid_r, "accepted item lost from stage A")
  `GDES_ASSERT_NEXT(p_hold_blocked, p_valid_r && !o_free, p_valid_r && $stable(p_pd_r), "blocked product stage changed")
  `GDES_ASSERT(o_level_range, p_go && (lvl_nxt != '0), (lvl_nxt >= floor_r) && (lvl_nxt <= max_r), "level outside floor and ceiling")
  `GDES_ASSERT(o_row_interior, out_valid_r, out_row_index_r != '0, "result on border row")

endmodule

`default_nettype wire

>>> tb/grid_diffusion_evaporation_step_tb.sv
// Self-checking testbench for the five-point diffusion and evaporation stencil.
`timescale 1ns / 1ps

module grid_diffusion_evaporation_step_tb;
  import gdes_pkg::*;

  localparam int LINE_CELLS  = 512;
  localparam int ROW_LIMIT   = 512;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {PACE_FULL, PACE_SENDER_SLOW, PACE_SINK_SLOW, PACE_BOTH_LIGHT} pace_t;

  typedef struct packed {
    logic [COEF_W-1:0] level;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } cell_update_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [15:0]          in_cell_level = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COEF_W-1:0]    out_new_level;
  logic [IDX_W-1:0]     out_row_index;
  logic [IDX_W-1:0]     out_col_index;
  logic                 out_frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // stencil predictor state
  logic [COEF_W-1:0] diff_k = DIFF_COEFF_RST;
  logic [COEF_W-1:0] keep_k = KEEP_COEFF_RST;
  logic [COEF_W-1:0] ceiling = MAX_LEVEL_RST;
  logic [COEF_W-1:0] floor_lvl = FLOOR_THRESHOLD_RST;
  logic [GEOM_W-1:0] len_reg = ROW_LENGTH_RST;
  logic [GEOM_W-1:0] rows_reg = ROW_COUNT_RST;
  bit [15:0]         row_above_buf [LINE_CELLS];
  bit [15:0]         row_two_above_buf [LINE_CELLS];
  bit [15:0]         taps [6];
  int unsigned       next_col = 0;
  int unsigned       next_row = 0;

  cell_update_t      expected_updates [$];
  cell_update_t      want;
  logic [15:0]       pending_cells [$];
  pace_t             pace = PACE_FULL;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;

  grid_diffusion_evaporation_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_level  (in_cell_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_level  (out_new_level),
    .out_row_index  (out_row_index),
    .out_col_index  (out_col_index),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned span(input logic [GEOM_W-1:0] v, input int unsigned top);
    if (v < GEOM_MIN) return GEOM_MIN;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] diffuse_level(input longint up, down, left, right,
                                                      center);
    longint acc;
    longint unsigned v;
    acc = longint'(diff_k) * (up + down + left + right - 4 * center)
          + 2 * longint'(keep_k) * center;
    if (acc < 0) return '0;
    v = (acc + 32768) >> 16;
    if (v > ceiling) v = ceiling;
    if (v < floor_lvl) v = 0;
    return v[COEF_W-1:0];
  endfunction

  function automatic void absorb_cell(input logic [15:0] x);
    int unsigned len, rows, c, r;
    bit [15:0] top_c, mid_c;
    cell_update_t upd;
    len = span(len_reg, LINE_CELLS);
    rows = span(rows_reg, ROW_LIMIT);
    c = next_col;
    r = next_row;
    top_c = row_two_above_buf[c];
    mid_c = row_above_buf[c];
    if (r >= 2 && r < rows && c >= 2 && c < len) begin
      upd.level = diffuse_level(taps[1], taps[5], taps[2], mid_c, taps[3]);
      upd.row = IDX_W'(r - 1);
      upd.col = IDX_W'(c - 1);
      upd.last = (r == rows - 1 && c == len - 1);
      expected_updates.push_back(upd);
    end
    taps[0] = taps[1];
    taps[1] = top_c;
    taps[2] = taps[3];
    taps[3] = mid_c;
    taps[4] = taps[5];
    taps[5] = x;
    row_two_above_buf[c] = mid_c;
    row_above_buf[c] = x;
    if (c + 1 >= len) begin
      next_col = 0;
      next_row = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function automatic int unsigned cells_to_frame_start();
    int unsigned c, r, n, len, rows;
    c = next_col;
    r = next_row;
    n = 0;
    len = span(len_reg, LINE_CELLS);
    rows = span(rows_reg, ROW_LIMIT);
    while (c != 0 || r != 0) begin
      if (c + 1 >= len) begin
        c = 0;
        r = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        c++;
      end
      n++;
    end
    return n;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] val);
    case (idx)
      CFG_DIFF_COEFF:      diff_k = val;
      CFG_KEEP_COEFF:      keep_k = val;
      CFG_MAX_LEVEL:       ceiling = val;
      CFG_FLOOR_THRESHOLD: floor_lvl = val;
      CFG_ROW_LENGTH:      len_reg = val[GEOM_W-1:0];
      CFG_ROW_COUNT:       rows_reg = val[GEOM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit sender_rests();
    case (pace)
      PACE_SENDER_SLOW: return $urandom_range(99) < 80;
      PACE_BOTH_LIGHT:  return $urandom_range(99) < 7;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (pace)
      PACE_SINK_SLOW:  return $urandom_range(99) < 80;
      PACE_BOTH_LIGHT: return $urandom_range(99) < 7;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] pick_level(input logic [15:0] base);
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      default: return base + 16'($urandom_range(1023)) - 16'd512;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // call at a rising edge; the caller lowers cfg_valid after the last write
  task automatic post_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic queue_cells(input int unsigned count, input logic [15:0] base);
    repeat (count) pending_cells.push_back(pick_level(base));
  endtask

  task automatic wait_until_settled();
    do @(negedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_updates.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input pace_t mode, input logic [15:0] d, k, mx, fl, lw, rw,
                           input int unsigned count, input bit whole_frame);
    logic [15:0] base;
    base = 16'($urandom);
    wait_until_settled();
    pace = mode;
    // widen rows only at a frame start so no stale line entry is used
    if (span(lw[GEOM_W-1:0], LINE_CELLS) > span(len_reg, LINE_CELLS)
        && (next_col != 0 || next_row != 0)) begin
      queue_cells(cells_to_frame_start(), base);
      wait_until_settled();
    end
    @(posedge clk);
    post_reg(CFG_DIFF_COEFF, d);
    post_reg(CFG_KEEP_COEFF, k);
    post_reg(CFG_MAX_LEVEL, mx);
    post_reg(CFG_FLOOR_THRESHOLD, fl);
    post_reg(CFG_ROW_LENGTH, lw);
    post_reg(CFG_ROW_COUNT, rw);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (whole_frame) count += cells_to_frame_start();
    queue_cells(count, base);
    wait_until_settled();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        absorb_cell(in_cell_level);
        void'(pending_cells.pop_front());
      end
      if (pending_cells.size() != 0 && !sender_rests()) begin
        in_valid <= 1'b1;
        in_cell_level <= pending_cells[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("unexpected item at (%0d,%0d)",
                                    out_row_index, out_col_index));
        end else begin
          want = expected_updates.pop_front();
          if (out_row_index !== want.row)
            report_mismatch($sformatf("row: got %0d want %0d", out_row_index, want.row));
          if (out_col_index !== want.col)
            report_mismatch($sformatf("col at row %0d: got %0d want %0d",
                                      want.row, out_col_index, want.col));
          if (out_new_level !== want.level)
            report_mismatch($sformatf("level at (%0d,%0d): got %h want %h",
                                      want.row, want.col, out_new_level, want.level));
          if (out_frame_last !== want.last)
            report_mismatch($sformatf("frame_last at (%0d,%0d): got %b want %b",
                                      want.row, want.col, out_frame_last, want.last));
        end
      end
      out_stall <= sink_stalls();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] d, k, mx, fl, lw, rw;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // 3x4 checkerboard: one cell pulled up by full neighbors, one pulled down
    @(posedge clk);
    post_reg(CFG_ROW_LENGTH, 16'hFC03);
    post_reg(CFG_ROW_COUNT, 16'h0004);
    post_reg(CFG_SPARE_LO, 16'hFFFF);
    post_reg(CFG_SPARE_HI, 16'h1234);
    cfg_valid <= 1'b0;
    @(negedge clk);
    for (int j = 0; j < 12; j++) pending_cells.push_back(j % 2 ? 16'hFFFF : 16'h0000);
    wait_until_settled();

    // same grid at extreme coefficients: saturate high, go negative
    @(posedge clk);
    post_reg(CFG_DIFF_COEFF, 16'hFFFF);
    post_reg(CFG_KEEP_COEFF, 16'd32768);
    post_reg(CFG_MAX_LEVEL, 16'hFFFF);
    post_reg(CFG_FLOOR_THRESHOLD, 16'h0000);
    cfg_valid <= 1'b0;
    @(negedge clk);
    for (int j = 0; j < 12; j++) pending_cells.push_back(j % 2 ? 16'hFFFF : 16'h0000);
    wait_until_settled();

    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(4))
        0:       d = 16'h0000;
        1:       d = 16'hFFFF;
        2:       d = 16'($urandom);
        default: d = 16'($urandom_range(8191));
      endcase
      case ($urandom_range(4))
        0:       k = 16'h0000;
        1:       k = 16'd32768;
        2:       k = 16'($urandom);
        default: k = 16'($urandom_range(32768, 16384));
      endcase
      case ($urandom_range(4))
        0:       mx = 16'h0000;
        1:       mx = 16'hFFFF;
        default: mx = 16'($urandom_range(65535, 1024));
      endcase
      case ($urandom_range(4))
        0:       fl = 16'h0000;
        1:       fl = 16'hFFFF;
        2:       fl = 16'($urandom);
        default: fl = 16'($urandom_range(1024));
      endcase
      lw = 16'($urandom) & 16'hFC00;
      rw = 16'($urandom) & 16'hFC00;
      lw[GEOM_W-1:0] = ($urandom_range(4) == 0) ? GEOM_W'($urandom_range(2))
                                                 : GEOM_W'($urandom_range(12, 3));
      rw[GEOM_W-1:0] = ($urandom_range(4) == 0) ? GEOM_W'($urandom_range(2))
                                                 : GEOM_W'($urandom_range(8, 3));
      run_phase(pace_t'(i % 4), d, k, mx, fl, lw, rw, $urandom_range(16, 8), 1'b0);
    end

    // widest rows, pass-through coefficients, then stop early in the third row
    run_phase(PACE_BOTH_LIGHT, 16'h0000, 16'd32768, 16'hFFFF, 16'h0000,
              16'hFFFF, 16'h0003, 2 * LINE_CELLS + 8, 1'b0);
    // narrow the rows mid-frame with a zero ceiling
    run_phase(PACE_SINK_SLOW, 16'd3000, 16'd32768, 16'h0000, 16'h0000,
              16'h0005, 16'h0004, 24, 1'b0);
    // short rows, run through to the last row of the frame
    run_phase(PACE_SENDER_SLOW, 16'd1200, 16'hFFFF, 16'h8000, 16'h0040,
              16'h0003, 16'h0008, 12, 1'b1);
    run_phase(PACE_FULL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
              16'h0006, 16'h0005, 24, 1'b0);

    wait_until_settled();
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
